FILE: rtl/cidr_pkg.sv
// Package for the CIDR text to address range parser.
// Holds the transfer payload types, parser phase enum and character codes.
// No dependencies.
package cidr_pkg;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] OCTET_MAX  = 8'd255;
    localparam logic [5:0] PREFIX_MAX = 6'd32;

    typedef enum logic [2:0] {
        PH_START,
        PH_OCTET,
        PH_AFTER4,
        PH_PREFIX,
        PH_IGNORE
    } t_phase;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [31:0] low_addr;
        logic [31:0] high_addr;
        logic        inverted;
        logic [5:0]  prefix_len;
        logic        value_clipped;
    } t_out;

endpackage

FILE: rtl/cidr_parse_core.sv
// Parser state machine and accumulators, one character per step.
// Produces the range result from the updated state on the last character.
// Depends on cidr_pkg.
module cidr_parse_core
    import cidr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in        i_item,
    output t_out       o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [7:0]  r_acc, n_acc;
    logic        r_stop, n_stop;
    logic [31:0] r_addr, n_addr;
    logic [5:0]  r_pfx, n_pfx;
    logic        r_inv, n_inv;
    logic        r_clip, n_clip;

    logic [7:0]  w_c;
    logic        w_digit;
    logic [3:0]  w_d;
    logic [11:0] w_oct_sum;
    logic [7:0]  w_oct_sat;
    logic        w_oct_over;
    logic [8:0]  w_pfx_sum;
    logic [5:0]  w_pfx_sat;
    logic [4:0]  w_sh;
    logic        w_oct_path;
    logic [31:0] w_mask;

    assign w_c        = i_item.text_char;
    assign w_digit    = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_d        = w_c[3:0];
    assign w_oct_sum  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {8'd0, w_d};
    assign w_oct_over = w_oct_sum > {4'd0, OCTET_MAX};
    assign w_oct_sat  = w_oct_over ? OCTET_MAX : w_oct_sum[7:0];
    assign w_pfx_sum  = {r_pfx, 3'b000} + {2'b00, r_pfx, 1'b0} + {5'd0, w_d};
    assign w_pfx_sat  = (w_pfx_sum > {3'd0, PREFIX_MAX}) ? PREFIX_MAX : w_pfx_sum[5:0];
    assign w_sh       = {2'd3 - r_idx, 3'b000};
    assign w_oct_path = (r_phase == PH_OCTET) || ((r_phase == PH_START) && (w_c != CH_BANG));

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_START, PH_OCTET: begin
                if ((r_phase == PH_START) && (w_c == CH_BANG)) begin
                    n_phase = PH_OCTET;
                end else if (w_c == CH_DOT) begin
                    n_phase = (r_idx == 2'd3) ? PH_AFTER4 : PH_OCTET;
                end else if (w_c == CH_SPACE) begin
                    n_phase = PH_IGNORE;
                end else if (w_c == CH_SLASH) begin
                    n_phase = PH_PREFIX;
                end else begin
                    n_phase = PH_OCTET;
                end
            end
            PH_AFTER4: n_phase = (w_c == CH_SLASH) ? PH_PREFIX : PH_IGNORE;
            PH_PREFIX: n_phase = (w_c == CH_SPACE) ? PH_IGNORE : PH_PREFIX;
            PH_IGNORE: n_phase = PH_IGNORE;
            default:   n_phase = PH_IGNORE;
        endcase
    end

    // accumulator updates
    always_comb begin
        n_idx  = r_idx;
        n_acc  = r_acc;
        n_stop = r_stop;
        n_addr = r_addr;
        n_pfx  = r_pfx;
        n_inv  = r_inv;
        n_clip = r_clip;
        if ((r_phase == PH_START) && (w_c == CH_BANG)) begin
            n_inv = 1'b1;
        end else if (w_oct_path) begin
            if (w_c == CH_DOT) begin
                if (r_idx != 2'd3) begin
                    n_idx  = r_idx + 2'd1;
                    n_acc  = 8'd0;
                    n_stop = 1'b0;
                end
            end else if (w_c == CH_SPACE) begin
                n_stop = r_stop;
            end else if (w_c == CH_SLASH) begin
                n_pfx  = 6'd0;
                n_stop = 1'b0;
            end else if (w_digit && !r_stop) begin
                n_acc              = w_oct_sat;
                n_addr[w_sh +: 8]  = w_oct_sat;
                n_clip             = r_clip | w_oct_over;
            end else begin
                n_stop = 1'b1;
            end
        end else if (r_phase == PH_AFTER4) begin
            if (w_c == CH_SLASH) begin
                n_pfx  = 6'd0;
                n_stop = 1'b0;
            end
        end else if (r_phase == PH_PREFIX) begin
            if (w_c == CH_SPACE) begin
                n_stop = r_stop;
            end else if (w_digit && !r_stop) begin
                n_pfx = w_pfx_sat;
            end else begin
                n_stop = 1'b1;
            end
        end
    end

    assign w_mask = ~(32'hFFFF_FFFF >> n_pfx);

    always_comb begin
        o_res.low_addr      = n_addr & w_mask;
        o_res.high_addr     = n_addr | ~w_mask;
        o_res.inverted      = n_inv;
        o_res.prefix_len    = n_pfx;
        o_res.value_clipped = n_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_char)) begin
            r_phase <= PH_START;
            r_idx   <= 2'd0;
            r_acc   <= 8'd0;
            r_stop  <= 1'b0;
            r_addr  <= 32'd0;
            r_pfx   <= PREFIX_MAX;
            r_inv   <= 1'b0;
            r_clip  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
            r_stop  <= n_stop;
            r_addr  <= n_addr;
            r_pfx   <= n_pfx;
            r_inv   <= n_inv;
            r_clip  <= n_clip;
        end
    end

endmodule

FILE: rtl/cidr_out_reg.sv
// Result register for the output channel, holds a result while stalled.
// Depends on cidr_pkg.
module cidr_out_reg
    import cidr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_out i_data,
    output logic o_busy,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic r_valid;
    t_out r_data;

    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

FILE: rtl/cidr_text_to_address_range.sv
// Top level of the CIDR text to address range parser.
// Input register, parser core and result register.
// Depends on cidr_pkg, cidr_parse_core, cidr_out_reg.
//
// Usage:
//   Input channel (i_in_valid, i_in_data, o_in_stall) carries one ASCII
//   character of a rule [!]a.b.c.d[/n] per transfer, last_char set on the
//   final character. Output channel (o_out_valid, o_out_data, i_out_stall)
//   carries one result per rule: low and high address, invert flag,
//   prefix length and octet clip flag.
//   Throughput: one character per cycle while o_in_stall is low. Each
//   character is held in the input register and then parsed by the
//   parser core, which updates its accumulators as it takes the character.
//   Result path: the last character passes the input register, then the
//   result register, whose valid then carries the result out.
//   Reset: synchronous, active low; clears the input and result valids and
//   returns the parser to the start of a rule, prefix 32.
//   Stall: a result waits in the result register while i_out_stall is high.
//   Non-final characters keep flowing; a final character waits in the
//   input register, and o_in_stall rises, until the result register frees.
module cidr_text_to_address_range
    import cidr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic r_in_valid;
    t_in  r_in;
    logic w_adv;
    logic w_out_busy;
    t_out w_res;

    assign w_adv      = r_in_valid && (!r_in.last_char || !w_out_busy);
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    cidr_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    cidr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv && r_in.last_char),
        .i_data  (w_res),
        .o_busy  (w_out_busy),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stall without a held item");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.last_char) |=> o_out_valid)
        else $error("final character did not produce a result");

    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.prefix_len <= PREFIX_MAX))
        else $error("prefix length above 32");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.low_addr & ~o_out_data.high_addr) == 32'd0))
        else $error("low address not covered by high address");
`endif

endmodule
